FILE: design/tmh_pkg.sv
// shared types, constants and helpers for the indexed min-heap timer queue
// no dependencies; imported by the interfaces, tmh_datapath, tmh_ctrl and the top module
package tmh_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int ID_COUNT_DEF = 256;

    localparam int ID_W      = 8;
    localparam int TIMEOUT_W = 31;
    localparam int TIME_W    = 32;

    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_RUN   = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_CLEAR = 2'd3
    } req_code_t;

    typedef enum logic [1:0] {
        EV_FIRED  = 2'd0,
        EV_DELAY  = 2'd1,
        EV_REJECT = 2'd2
    } ev_code_t;

    typedef struct packed {
        logic [TIME_W-1:0] expiry;
        logic [ID_W-1:0]   owner;
    } tmh_entry_t;

    // datapath operations, one per cycle
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_CLEAR,
        OP_SLOT_RD,
        OP_HEAP_RD_SLOT,
        OP_ARM_OLD,
        OP_ARM_NEW,
        OP_REM,
        OP_REM_TAKE,
        OP_UP_RD,
        OP_UP_MOVE,
        OP_DN_RD_L,
        OP_DN_TAKE_L,
        OP_DN_TAKE_R,
        OP_DN_MOVE,
        OP_FINAL,
        OP_TICK_RD,
        OP_TICK_CHK,
        OP_EMIT_REJ,
        OP_EMIT_RUN,
        OP_EMIT_FIRE,
        OP_EMIT_REP
    } dp_op_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       id_ok;
        logic       armed;
        logic       full;
        logic       empty;
        logic       pos_zero;
        logic       pos_in;
        logic       has_left;
        logic       has_right;
        logic       par_earlier;
        logic       pick_earlier;
        logic       tick_fire;
        logic       out_free;
    } tmh_status_t;

    // heap order: expiry unsigned, ties to the smaller id
    function automatic logic earlier(tmh_entry_t a, tmh_entry_t b);
        logic r;
        if (a.expiry != b.expiry)
            r = a.expiry < b.expiry;
        else
            r = a.owner < b.owner;
        return r;
    endfunction

endpackage

FILE: design/tmh_req_if.sv
// request channel of the timer queue: valid/ready plus request payload
// depends on tmh_pkg
interface tmh_req_if
    import tmh_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [1:0]           req_type;
    logic [ID_W-1:0]      timer_id;
    logic [TIMEOUT_W-1:0] timeout_ms;
    logic [TIME_W-1:0]    now_ms;

    modport source (output valid, req_type, timer_id, timeout_ms, now_ms, input ready);
    modport sink (input valid, req_type, timer_id, timeout_ms, now_ms, output ready);
endinterface

FILE: design/tmh_evt_if.sv
// event channel of the timer queue: valid/ready plus result payload
// depends on tmh_pkg
interface tmh_evt_if
    import tmh_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [1:0]               event_kind;
    logic [ID_W-1:0]          fired_id;
    logic signed [TIME_W-1:0] delay_ms;
    logic                     last;

    modport source (output valid, event_kind, fired_id, delay_ms, last, input ready);
    modport sink (input valid, event_kind, fired_id, delay_ms, last, output ready);
endinterface

FILE: design/tmh_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
module tmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

FILE: design/tmh_datapath.sv
// timer queue datapath: request registers, heap and slot memories, sift registers,
// output register; depends on tmh_pkg and tmh_ram
module tmh_datapath
    import tmh_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int ID_COUNT = ID_COUNT_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_op_t                   op,
    output tmh_status_t              status,
    input  logic [1:0]               req_type,
    input  logic [ID_W-1:0]          timer_id,
    input  logic [TIMEOUT_W-1:0]     timeout_ms,
    input  logic [TIME_W-1:0]        now_ms,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               event_kind,
    output logic [ID_W-1:0]          fired_id,
    output logic signed [TIME_W-1:0] delay_ms,
    output logic                     last
);
    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = PW + 2;
    localparam int IW = $clog2(ID_COUNT);
    localparam int EW = $bits(tmh_entry_t);

    logic [1:0]           req_type_reg;
    logic [ID_W-1:0]      id_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [CW-1:0]        count_reg, count_next;
    logic [PW-1:0]        pos_reg;
    logic [PW-1:0]        pidx_reg;
    tmh_entry_t           cur_reg;
    tmh_entry_t           pick_reg;
    logic [ID_W-1:0]      hd_own_reg;
    logic [TIME_W-1:0]    diff_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           kind_reg;
    logic [ID_W-1:0]      fid_reg;
    logic [TIME_W-1:0]    delay_reg;
    logic                 last_reg;

    logic                 heap_we;
    logic [PW-1:0]        heap_waddr, heap_raddr;
    tmh_entry_t           heap_wdata, heap_rdata;
    logic [EW-1:0]        heap_rbits;
    logic                 slot_we;
    logic [IW-1:0]        slot_waddr, slot_raddr;
    logic [PW-1:0]        slot_wdata, slot_rdata;

    logic [XW-1:0]        pos_x, count_x, left_x, right_x;
    logic [PW-1:0]        up_idx, tail_idx;
    logic [TIME_W-1:0]    when_ms, diff;
    tmh_entry_t           new_entry;
    logic                 emit;

    assign heap_rdata = tmh_entry_t'(heap_rbits);

    tmh_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_heap (
        .clk   (clk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .raddr (heap_raddr),
        .rdata (heap_rbits)
    );

    tmh_ram #(.WIDTH(PW), .DEPTH(ID_COUNT)) u_slot (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    assign pos_x    = XW'(pos_reg);
    assign count_x  = XW'(count_reg);
    assign left_x   = XW'({pos_reg, 1'b1});
    assign right_x  = left_x + XW'(1);
    assign up_idx   = PW'((pos_reg - PW'(1)) >> 1);
    assign tail_idx = PW'(count_reg - CW'(1));
    assign when_ms  = now_reg + TIME_W'(timeout_reg);
    assign diff     = heap_rdata.expiry - now_reg;
    assign new_entry.expiry = when_ms;
    assign new_entry.owner  = id_reg;

    always_comb
    begin
        status.req_type     = req_type_reg;
        status.id_ok        = 32'(id_reg) < 32'(ID_COUNT);
        // an id is armed when its slot points inside the heap at an entry it owns
        status.armed        = (pos_x < count_x) && (heap_rdata.owner == id_reg);
        status.full         = count_reg >= CW'(CAPACITY);
        status.empty        = count_reg == '0;
        status.pos_zero     = pos_reg == '0;
        status.pos_in       = pos_x < count_x;
        status.has_left     = left_x < count_x;
        status.has_right    = right_x < count_x;
        status.par_earlier  = earlier(cur_reg, heap_rdata);
        status.pick_earlier = earlier(pick_reg, cur_reg);
        // wrap-safe: remaining time zero or negative
        status.tick_fire    = (diff == '0) || diff[TIME_W-1];
        status.out_free     = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        heap_we    = 1'b0;
        heap_waddr = pos_reg;
        heap_wdata = cur_reg;
        heap_raddr = pos_reg;
        slot_we    = 1'b0;
        slot_waddr = IW'(cur_reg.owner);
        slot_wdata = pos_reg;
        slot_raddr = IW'(id_reg);
        case (op)
            OP_HEAP_RD_SLOT: heap_raddr = slot_rdata;
            OP_REM:          heap_raddr = tail_idx;
            OP_UP_RD:        heap_raddr = up_idx;
            OP_DN_RD_L:      heap_raddr = PW'(left_x);
            OP_DN_TAKE_L:    heap_raddr = PW'(right_x);
            OP_TICK_RD:      heap_raddr = '0;
            OP_UP_MOVE:
            begin
                heap_we    = 1'b1;
                heap_wdata = heap_rdata;
                slot_we    = 1'b1;
                slot_waddr = IW'(heap_rdata.owner);
            end
            OP_DN_MOVE:
            begin
                heap_we    = 1'b1;
                heap_wdata = pick_reg;
                slot_we    = 1'b1;
                slot_waddr = IW'(pick_reg.owner);
            end
            OP_FINAL:
            begin
                heap_we = 1'b1;
                slot_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign emit = (op == OP_EMIT_REJ) || (op == OP_EMIT_RUN) ||
                  (op == OP_EMIT_FIRE) || (op == OP_EMIT_REP);

    always_comb
    begin
        count_next = count_reg;
        case (op)
            OP_CLEAR:   count_next = '0;
            OP_ARM_NEW: count_next = count_reg + CW'(1);
            OP_REM:     count_next = count_reg - CW'(1);
            default:    count_next = count_reg;
        endcase
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            OP_LATCH:
            begin
                req_type_reg <= req_type;
                id_reg       <= timer_id;
                timeout_reg  <= timeout_ms;
                now_reg      <= now_ms;
            end
            OP_HEAP_RD_SLOT: pos_reg <= slot_rdata;
            OP_ARM_OLD:      cur_reg <= new_entry;
            OP_ARM_NEW:
            begin
                cur_reg <= new_entry;
                pos_reg <= PW'(count_reg);
            end
            OP_REM_TAKE:     cur_reg <= heap_rdata;
            OP_UP_MOVE:      pos_reg <= up_idx;
            OP_DN_TAKE_L:
            begin
                pick_reg <= heap_rdata;
                pidx_reg <= PW'(left_x);
            end
            OP_DN_TAKE_R:
            begin
                if (earlier(heap_rdata, pick_reg))
                begin
                    pick_reg <= heap_rdata;
                    pidx_reg <= PW'(right_x);
                end
            end
            OP_DN_MOVE:      pos_reg <= pidx_reg;
            OP_TICK_CHK:
            begin
                hd_own_reg <= heap_rdata.owner;
                diff_reg   <= diff;
                pos_reg    <= '0;
            end
            OP_EMIT_REJ:
            begin
                kind_reg  <= EV_REJECT;
                fid_reg   <= id_reg;
                delay_reg <= '0;
                last_reg  <= 1'b1;
            end
            OP_EMIT_RUN:
            begin
                kind_reg  <= EV_FIRED;
                fid_reg   <= id_reg;
                delay_reg <= '0;
                last_reg  <= 1'b1;
            end
            OP_EMIT_FIRE:
            begin
                kind_reg  <= EV_FIRED;
                fid_reg   <= hd_own_reg;
                delay_reg <= '0;
                last_reg  <= 1'b0;
            end
            OP_EMIT_REP:
            begin
                kind_reg  <= EV_DELAY;
                fid_reg   <= '0;
                delay_reg <= (count_reg == '0) ? '1 : diff_reg;
                last_reg  <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = kind_reg;
    assign fired_id   = fid_reg;
    assign delay_ms   = delay_reg;
    assign last       = last_reg;
endmodule

FILE: design/tmh_ctrl.sv
// timer queue controller: request dispatch, sift sequencing and result timing
// depends on tmh_pkg
module tmh_ctrl
    import tmh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  tmh_status_t status,
    output dp_op_t      op
);
    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_HRD,
        S_DECIDE,
        S_EMIT_REJ,
        S_REM,
        S_REM_T,
        S_UP,
        S_UPC,
        S_DN,
        S_DNL,
        S_DNR,
        S_DNDEC,
        S_FIN,
        S_EMIT_RUN,
        S_TICK,
        S_TCHK,
        S_EMIT_FIRE,
        S_EMIT_REP
    } state_t;

    state_t state_reg, state_next;
    state_t ret_state;

    // where to go once a removal or a sift is done
    always_comb
    begin
        case (req_code_t'(status.req_type))
            REQ_RUN:  ret_state = S_EMIT_RUN;
            REQ_TICK: ret_state = S_TICK;
            default:  ret_state = S_IDLE;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = OP_LATCH;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (req_code_t'(status.req_type))
                    REQ_TICK:  state_next = S_TICK;
                    REQ_CLEAR:
                    begin
                        op         = OP_CLEAR;
                        state_next = S_IDLE;
                    end
                    default:
                    begin
                        if (status.id_ok)
                        begin
                            op         = OP_SLOT_RD;
                            state_next = S_HRD;
                        end
                        else
                            state_next = S_IDLE;
                    end
                endcase
            end
            S_HRD:
            begin
                op         = OP_HEAP_RD_SLOT;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (req_code_t'(status.req_type) == REQ_ADD)
                begin
                    if (status.armed)
                    begin
                        op         = OP_ARM_OLD;
                        state_next = S_UP;
                    end
                    else if (status.full)
                        state_next = S_EMIT_REJ;
                    else
                    begin
                        op         = OP_ARM_NEW;
                        state_next = S_UP;
                    end
                end
                else if (status.armed)
                begin
                    op         = OP_REM;
                    state_next = S_REM_T;
                end
                else
                    state_next = S_IDLE;
            end
            S_EMIT_REJ:
            begin
                if (status.out_free)
                begin
                    op         = OP_EMIT_REJ;
                    state_next = S_IDLE;
                end
            end
            S_REM:
            begin
                op         = OP_REM;
                state_next = S_REM_T;
            end
            S_REM_T:
            begin
                // tail entry moves into the hole unless the hole was the tail
                op         = OP_REM_TAKE;
                state_next = status.pos_in ? S_UP : ret_state;
            end
            S_UP:
            begin
                if (status.pos_zero)
                    state_next = S_DN;
                else
                begin
                    op         = OP_UP_RD;
                    state_next = S_UPC;
                end
            end
            S_UPC:
            begin
                if (status.par_earlier)
                begin
                    op         = OP_UP_MOVE;
                    state_next = S_UP;
                end
                else
                    state_next = S_DN;
            end
            S_DN:
            begin
                if (status.has_left)
                begin
                    op         = OP_DN_RD_L;
                    state_next = S_DNL;
                end
                else
                    state_next = S_FIN;
            end
            S_DNL:
            begin
                op         = OP_DN_TAKE_L;
                state_next = status.has_right ? S_DNR : S_DNDEC;
            end
            S_DNR:
            begin
                op         = OP_DN_TAKE_R;
                state_next = S_DNDEC;
            end
            S_DNDEC:
            begin
                if (status.pick_earlier)
                begin
                    op         = OP_DN_MOVE;
                    state_next = S_DN;
                end
                else
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                op         = OP_FINAL;
                state_next = ret_state;
            end
            S_EMIT_RUN:
            begin
                if (status.out_free)
                begin
                    op         = OP_EMIT_RUN;
                    state_next = S_IDLE;
                end
            end
            S_TICK:
            begin
                if (status.empty)
                    state_next = S_EMIT_REP;
                else
                begin
                    op         = OP_TICK_RD;
                    state_next = S_TCHK;
                end
            end
            S_TCHK:
            begin
                op         = OP_TICK_CHK;
                state_next = status.tick_fire ? S_EMIT_FIRE : S_EMIT_REP;
            end
            S_EMIT_FIRE:
            begin
                if (status.out_free)
                begin
                    op         = OP_EMIT_FIRE;
                    state_next = S_REM;
                end
            end
            S_EMIT_REP:
            begin
                if (status.out_free)
                begin
                    op         = OP_EMIT_REP;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = state_reg == S_IDLE;
endmodule

FILE: design/timer_min_heap_with_index_unit.sv
// Timer queue kept as a binary min-heap of (expiry, id) in a memory, with a per-id
// slot memory so add/rearm and run-now find an entry directly. One request is worked
// at a time; a request beat is taken whenever the controller is idle, even while the
// last result still waits in the output register. The heap memory has one read port,
// so a sift reads one heap entry at a time. Add and rearm write the new expiry and
// sift it up, then down; an add of a new id to a full heap is rejected. Run-now ends
// without a result on an unknown or unarmed id; otherwise the tail entry fills the
// removed slot and is sifted unless the removed entry was the tail, and the id is
// then reported as fired. Tick reports each expired head timer and removes it, then
// reports the delay to the next expiry, or an all-ones delay on an empty heap; clear
// empties the heap. Every result waits while the output register still holds an
// unaccepted beat. No clearing pass is needed after reset: an id counts as armed
// only when its slot lies inside the heap and the entry there carries that id.
// Depends on tmh_pkg, the channel interfaces, tmh_ctrl and tmh_datapath.
module timer_min_heap_with_index_unit
    import tmh_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int ID_COUNT = ID_COUNT_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    tmh_req_if.sink   req,
    tmh_evt_if.source evt
);
    dp_op_t      op;
    tmh_status_t status;

    tmh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .status   (status),
        .op       (op)
    );

    tmh_datapath #(.CAPACITY(CAPACITY), .ID_COUNT(ID_COUNT)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .status     (status),
        .req_type   (req.req_type),
        .timer_id   (req.timer_id),
        .timeout_ms (req.timeout_ms),
        .now_ms     (req.now_ms),
        .out_valid  (evt.valid),
        .out_ready  (evt.ready),
        .event_kind (evt.event_kind),
        .fired_id   (evt.fired_id),
        .delay_ms   (evt.delay_ms),
        .last       (evt.last)
    );
endmodule
